### design/ism_pkg.sv
`default_nettype none
package ism_pkg;
  localparam int MaxIntervals = 64;
  localparam int AddrW = $clog2(MaxIntervals);
  localparam int CntW = $clog2(MaxIntervals + 1);

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic command;
    logic signed [31:0] range_start;
    logic signed [31:0] range_end;
  } in_req_t;

  typedef struct packed {
    logic covered;
    logic table_full;
    logic [CntW-1:0] entry_count;
  } out_req_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } ival_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_DONE
  } ism_state_t;

  // Memory port request from the controller.
  typedef struct packed {
    logic re;
    logic [AddrW-1:0] raddr;
    logic we;
    logic [AddrW-1:0] waddr;
    ival_t wdata;
  } mem_req_t;
endpackage
`default_nettype wire

### design/ism_mem.sv
`default_nettype none
module ism_mem import ism_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output ival_t         rdata
);
  ival_t mem [MaxIntervals];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule
`default_nettype wire

### design/ism_ctrl.sv
`default_nettype none
module ism_ctrl import ism_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_req_t      out_data,
  output mem_req_t      mreq,
  input  wire ival_t    rdata
);
  // Scan phase: read entries 0..n-1 in order, find first and last of the merge run,
  // or covering entry. Move phase: copy entries to compact or make room.
  ism_state_t state_r, state_nxt;
  in_req_t req_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;     // next address to issue
  logic pend_r, pend_nxt;              // read data valid this cycle
  logic [CntW-1:0] pidx_r, pidx_nxt;   // index of the data in rdata
  logic [CntW-1:0] first_r, first_nxt;
  logic [CntW-1:0] last_r, last_nxt;
  logic found_r, found_nxt;            // first found
  logic stop_r, stop_nxt;              // run ended
  logic cov_r, cov_nxt;
  logic full_r, full_nxt;
  logic signed [32:0] nlo_r, nlo_nxt, nhi_r, nhi_nxt;
  // Move: source index src, dest = src - removed (compact) or src+1 (insert).
  logic [CntW-1:0] src_r, src_nxt;
  logic [CntW-1:0] end_r, end_nxt;
  logic ins_r, ins_nxt;
  logic [CntW-1:0] rem_r, rem_nxt;
  out_req_t res_r, res_nxt;
  logic ovalid_r, ovalid_nxt;

  logic signed [32:0] lo33, hi33, rlo33, rhi33;
  logic hit, reaches, starts_ok;
  logic [CntW-1:0] dest;

  assign lo33 = {req_r.range_start[31], req_r.range_start};
  assign hi33 = {req_r.range_end[31], req_r.range_end};
  assign rlo33 = {rdata.lo[31], rdata.lo};
  assign rhi33 = {rdata.hi[31], rdata.hi};
  assign reaches = (rhi33 + 33'sd1) >= lo33;
  assign starts_ok = rlo33 <= (hi33 + 33'sd1);
  assign hit = (rlo33 <= lo33) && (hi33 <= rhi33);
  assign dest = ins_r ? src_r + CntW'(1) : src_r - rem_r - CntW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && !in_stall) begin
      req_r <= in_data;
    end
    idx_r <= idx_nxt;
    pidx_r <= pidx_nxt;
    first_r <= first_nxt;
    last_r <= last_nxt;
    found_r <= found_nxt;
    stop_r <= stop_nxt;
    cov_r <= cov_nxt;
    full_r <= full_nxt;
    nlo_r <= nlo_nxt;
    nhi_r <= nhi_nxt;
    src_r <= src_nxt;
    end_r <= end_nxt;
    ins_r <= ins_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (in_data.range_start > in_data.range_end) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!pend_r && (idx_r >= cnt_r || stop_r)) begin
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (!pend_r && src_r == end_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    pend_nxt = 1'b0;
    pidx_nxt = pidx_r;
    first_nxt = first_r;
    last_nxt = last_r;
    found_nxt = found_r;
    stop_nxt = stop_r;
    cov_nxt = cov_r;
    full_nxt = full_r;
    nlo_nxt = nlo_r;
    nhi_nxt = nhi_r;
    src_nxt = src_r;
    end_nxt = end_r;
    ins_nxt = ins_r;
    rem_nxt = rem_r;
    res_nxt = res_r;
    ovalid_nxt = ovalid_r && out_stall;
    mreq = '0;
    in_stall = (state_r != ST_IDLE) || (ovalid_r && out_stall);
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        found_nxt = 1'b0;
        stop_nxt = 1'b0;
        cov_nxt = 1'b0;
        full_nxt = 1'b0;
        nlo_nxt = {in_data.range_start[31], in_data.range_start};
        nhi_nxt = {in_data.range_end[31], in_data.range_end};
        first_nxt = cnt_r;
        last_nxt = cnt_r;
      end
      ST_SCAN: begin
        if (pend_r) begin
          if (req_r.command == CmdQuery) begin
            if (hit) begin
              cov_nxt = 1'b1;
              stop_nxt = 1'b1;
            end
          end else if (!found_r) begin
            if (reaches) begin
              found_nxt = 1'b1;
              first_nxt = pidx_r;
              if (starts_ok) begin
                last_nxt = pidx_r + CntW'(1);
                if (rlo33 < nlo_r) nlo_nxt = rlo33;
                if (rhi33 > nhi_r) nhi_nxt = rhi33;
              end else begin
                last_nxt = pidx_r;
                stop_nxt = 1'b1;
              end
            end
          end else if (starts_ok) begin
            last_nxt = pidx_r + CntW'(1);
            if (rhi33 > nhi_r) nhi_nxt = rhi33;
          end else begin
            stop_nxt = 1'b1;
          end
        end
        // Issue next read unless finished or the last result stops the scan.
        if (idx_r < cnt_r && !stop_nxt) begin
          mreq.re = 1'b1;
          mreq.raddr = idx_r[AddrW-1:0];
          pidx_nxt = idx_r;
          idx_nxt = idx_r + CntW'(1);
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          // Set up the move phase.
          ins_nxt = 1'b0;
          rem_nxt = '0;
          src_nxt = cnt_r;
          end_nxt = cnt_r;
          if (req_r.command == CmdAdd) begin
            if (last_r > first_r) begin
              // Write merged entry, compact the tail.
              mreq.we = 1'b1;
              mreq.waddr = first_r[AddrW-1:0];
              mreq.wdata.lo = nlo_r[31:0];
              mreq.wdata.hi = nhi_r[31:0];
              rem_nxt = last_r - first_r - CntW'(1);
              src_nxt = last_r;
              end_nxt = cnt_r;
              cnt_nxt = cnt_r - (last_r - first_r - CntW'(1));
            end else if (cnt_r >= CntW'(MaxIntervals)) begin
              full_nxt = 1'b1;
            end else begin
              // Shift [first, cnt) up by one, from the top down.
              ins_nxt = 1'b1;
              src_nxt = cnt_r;
              end_nxt = first_r;
            end
          end
          if (rem_nxt == '0 && !ins_nxt) begin
            src_nxt = end_nxt;
          end
        end
      end
      ST_MOVE: begin
        if (pend_r) begin
          mreq.we = 1'b1;
          mreq.waddr = dest[AddrW-1:0];
          mreq.wdata = rdata;
        end
        if (!pend_r && src_r == end_r) begin
          if (ins_r) begin
            mreq.we = 1'b1;
            mreq.waddr = first_r[AddrW-1:0];
            mreq.wdata.lo = req_r.range_start;
            mreq.wdata.hi = req_r.range_end;
            cnt_nxt = cnt_r + CntW'(1);
          end
        end else if (pend_r) begin
          // Wait for the write to land before the next read.
        end else if (ins_r) begin
          mreq.re = 1'b1;
          mreq.raddr = AddrW'(src_r - CntW'(1));
          src_nxt = src_r - CntW'(1);
          pend_nxt = 1'b1;
        end else begin
          mreq.re = 1'b1;
          mreq.raddr = src_r[AddrW-1:0];
          src_nxt = src_r + CntW'(1);
          pend_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        ovalid_nxt = 1'b1;
        res_nxt.covered = cov_r;
        res_nxt.table_full = full_r;
        res_nxt.entry_count = cnt_r;
      end
      default: ;
    endcase
  end

  // dest uses src after decrement (insert) or one past the read index (compact).
  assign out_valid = ovalid_r;
  assign out_data = res_r;

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntW'(MaxIntervals))
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |-> !(out_data.covered && out_data.table_full))
    else $error("covered and full together");
  assert property (@(posedge clk) disable iff (!rst_n)
    mreq.we && mreq.re |-> mreq.waddr != mreq.raddr || state_r == ST_SCAN)
    else $error("read and write of one entry collide");
endmodule
`default_nettype wire

### design/interval_set_merge_query_core.sv
`default_nettype none
// Channel  | Dir | Payload    | Handshake
// in_      | in  | in_req_t   | in_valid / in_stall
// out_     | out | out_req_t  | out_valid / out_stall
// One request at a time. A query or add with start <= end scans stored entries one
// per cycle from the memory's single read port; an add then compacts or shifts the
// tail, reading each moved entry and writing it back before the next read.
// Reset (rst_n low, synchronous) empties the table; no clearing pass is needed.
// A finished result waits in the output register while out_stall is high.
module interval_set_merge_query_core import ism_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_req_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_req_t     out_data
);
  mem_req_t mreq;
  ival_t rdata;

  ism_mem u_mem (.clk(clk), .req(mreq), .rdata(rdata));

  ism_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .mreq(mreq), .rdata(rdata)
  );
endmodule
`default_nettype wire
